// File: design/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, codes and helpers for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int START_W = 16;
  localparam int LEN_W   = 17;
  localparam int COUNT_W = 5;

  localparam int MAX_SEGMENTS_DEF    = 16;
  localparam int HEAP_MAX_BLOCKS_DEF = 65536;

  localparam logic [LEN_W-1:0] LEN_MAX       = '1;
  localparam logic [LEN_W-1:0] HEAP_RESET    = 17'h10000;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic REG_HEAP_BLOCKS = 1'b0;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_ZERO  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ASCAN,
    ST_SHDN,
    ST_FSCAN,
    ST_FDECIDE,
    ST_MERGE,
    ST_SHUP,
    ST_INSERT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [START_W-1:0] start;
  } entry_t;

  // saturate a merged length to the field range
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W+1:0] v);
    sat_len = (v > {2'b00, LEN_MAX}) ? LEN_MAX : v[LEN_W-1:0];
  endfunction

endpackage

// File: design/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a heap of blocks with an address-ordered free
// segment table, merging freed segments with touching neighbors.
// ----------------------------------------------------------------------------
// One request is handled at a time; s_tready is high only while the sequencer
// is idle, and a new request may enter while the previous result still waits
// on the master side. The free table sits in a RAM with one write and one
// registered read port, and the sequencer walks it one entry per cycle.
// Init and rejected requests go straight to the result. Alloc scans for the
// first segment that fits and, when that segment is used up exactly, moves
// the entries after it down. Free scans for the first segment at or above
// the freed index, and shifts the table open for a new entry or closed after
// a two-sided merge. A free that shifts the table stops its scan where the
// shift starts. After reset the block writes the initial segment before it
// accepts a request.
// ----------------------------------------------------------------------------
module first_fit_block_allocator import ffa_pkg::*; #(
  parameter int MAX_SEGMENTS    = MAX_SEGMENTS_DEF,
  parameter int HEAP_MAX_BLOCKS = HEAP_MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream: [1:0] operation, [18:2] size_blocks, [34:19] block_index
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // master stream: [1:0] status, [17:2] start_block, [22:18] free_count
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = $bits(entry_t);
  localparam logic [LEN_W-1:0] HeapCap =
    LEN_W'((HEAP_MAX_BLOCKS > 131071) ? 131071 : HEAP_MAX_BLOCKS);

  state_t state, state_next;

  logic [LEN_W-1:0]   heap_blocks;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      ptr;
  logic [CW-1:0]      pos;
  logic [IW-1:0]      rd_idx;
  logic               dv;
  logic [LEN_W-1:0]   size_r;
  logic [START_W-1:0] idx_r;
  logic [START_W-1:0] prev_start;
  logic [LEN_W-1:0]   prev_len;
  logic               prev_valid;
  logic [START_W-1:0] cur_start;
  logic [LEN_W-1:0]   cur_len;
  logic               cur_valid;
  logic [LEN_W:0]     acc;
  status_t            status_r;
  logic [START_W-1:0] start_r;

  logic [1:0]         out_status;
  logic [START_W-1:0] out_start;
  logic [COUNT_W-1:0] out_count;

  // RAM ports
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic [IW-1:0] rd_addr;
  logic [EW-1:0] ram_rdata;
  entry_t        rdata;

  logic [1:0]         in_op;
  logic [LEN_W-1:0]   in_size;
  logic [START_W-1:0] in_idx;
  logic               in_acc;
  logic               out_free;
  logic [LEN_W-1:0]   heap_eff;

  logic           issue_fwd;
  logic           last_fwd;
  logic           fit;
  logic           exact;
  logic           below;
  logic           left_hit;
  logic           right_hit;
  logic           full;
  logic           shdn_end;
  logic           shup_end;
  logic [LEN_W:0] grow_left;
  logic [LEN_W:0] grow_right;
  logic [LEN_W+1:0] merge_sum;

  assign in_op   = s_tdata[1:0];
  assign in_size = s_tdata[18:2];
  assign in_idx  = s_tdata[34:19];

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign heap_eff = (heap_blocks > HeapCap) ? HeapCap : heap_blocks;

  assign rdata = ram_rdata;

  assign issue_fwd = (ptr < cnt);
  assign last_fwd  = dv && (CW'(rd_idx) == cnt - CW'(1));
  assign fit       = (size_r <= rdata.len);
  assign exact     = (size_r == rdata.len);
  assign below     = (rdata.start < idx_r);
  assign full      = (cnt == CW'(MAX_SEGMENTS));

  assign left_hit  = prev_valid &&
                     (({2'b00, prev_start} + {1'b0, prev_len}) == {2'b00, idx_r});
  assign right_hit = cur_valid &&
                     (({2'b00, idx_r} + {1'b0, size_r}) == {2'b00, cur_start});

  assign grow_left  = {1'b0, prev_len} + {1'b0, size_r};
  assign grow_right = {1'b0, cur_len} + {1'b0, size_r};
  assign merge_sum  = {1'b0, acc} + {2'b00, cur_len};

  assign shdn_end = last_fwd || (!dv && !issue_fwd);
  assign shup_end = (dv && (CW'(rd_idx) == pos)) || (!dv && (ptr <= pos));

  ffa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          priority case (1'b1)
            (in_op == OP_ALLOC) && (in_size != '0) && (cnt != '0):
              state_next = ST_ASCAN;
            (in_op == OP_FREE) && (in_size != '0) && (cnt != '0):
              state_next = ST_FSCAN;
            (in_op == OP_FREE) && (in_size != '0):
              state_next = ST_FDECIDE;
            default:
              state_next = ST_DONE;
          endcase
        end
      end
      ST_ASCAN: begin
        if (dv && fit) begin
          state_next = exact ? ST_SHDN : ST_DONE;
        end else if (last_fwd) begin
          state_next = ST_DONE;
        end
      end
      ST_SHDN: begin
        if (shdn_end) begin
          state_next = ST_DONE;
        end
      end
      ST_FSCAN: begin
        if (dv && (!below || last_fwd)) begin
          state_next = ST_FDECIDE;
        end
      end
      ST_FDECIDE: begin
        priority if (left_hit && right_hit) begin
          state_next = ST_MERGE;
        end else if (left_hit || right_hit || full) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SHUP;
        end
      end
      ST_MERGE: begin
        state_next = ST_SHDN;
      end
      ST_SHUP: begin
        if (shup_end) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------- table access
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_addr = '0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '{len: HEAP_RESET, start: '0};
      end
      ST_IDLE: begin
        if (in_acc && (in_op == OP_INIT) && (heap_eff != '0)) begin
          wr_en   = 1'b1;
          wr_data = '{len: heap_eff, start: '0};
        end
      end
      ST_ASCAN: begin
        rd_addr = ptr[IW-1:0];
        if (dv && fit && !exact) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx;
          wr_data = '{len: rdata.len - size_r,
                      start: rdata.start + size_r[START_W-1:0]};
        end
      end
      ST_SHDN: begin
        rd_addr = ptr[IW-1:0];
        if (dv) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx - IW'(1);
          wr_data = rdata;
        end
      end
      ST_FSCAN: begin
        rd_addr = ptr[IW-1:0];
      end
      ST_FDECIDE: begin
        if (left_hit && !right_hit) begin
          wr_en   = 1'b1;
          wr_addr = IW'(pos - CW'(1));
          wr_data = '{len: sat_len({1'b0, grow_left}), start: prev_start};
        end else if (right_hit && !left_hit) begin
          wr_en   = 1'b1;
          wr_addr = pos[IW-1:0];
          wr_data = '{len: sat_len({1'b0, grow_right}), start: idx_r};
        end
      end
      ST_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = IW'(pos - CW'(1));
        wr_data = '{len: sat_len(merge_sum), start: prev_start};
      end
      ST_SHUP: begin
        rd_addr = IW'(ptr - CW'(1));
        if (dv) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx + IW'(1);
          wr_data = rdata;
        end
      end
      ST_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = pos[IW-1:0];
        wr_data = '{len: size_r, start: idx_r};
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= CW'(1);
      dv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          dv <= 1'b0;
          if (in_acc && (in_op == OP_INIT)) begin
            cnt <= (heap_eff == '0) ? '0 : CW'(1);
          end
        end
        ST_ASCAN, ST_FSCAN: begin
          dv <= issue_fwd;
          if (state == ST_ASCAN && dv && fit && exact) begin
            dv <= 1'b0;
          end
        end
        ST_SHDN: begin
          dv <= issue_fwd;
          if (shdn_end) begin
            cnt <= cnt - CW'(1);
          end
        end
        ST_FDECIDE, ST_MERGE: begin
          dv <= 1'b0;
        end
        ST_SHUP: begin
          dv <= (ptr > pos);
        end
        ST_INSERT: begin
          cnt <= cnt + CW'(1);
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------------- datapath regs
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          size_r     <= in_size;
          idx_r      <= in_idx;
          start_r    <= '0;
          ptr        <= '0;
          prev_valid <= 1'b0;
          cur_valid  <= 1'b0;
          pos        <= '0;
          status_r   <= STAT_OK;
          if ((in_op == OP_ALLOC) || (in_op == OP_FREE)) begin
            if (in_size == '0) begin
              status_r <= STAT_ZERO;
            end else if ((in_op == OP_ALLOC) && (cnt == '0)) begin
              status_r <= STAT_NOFIT;
            end
          end
        end
      end
      ST_ASCAN: begin
        rd_idx <= ptr[IW-1:0];
        if (issue_fwd) begin
          ptr <= ptr + CW'(1);
        end
        if (dv && fit) begin
          start_r <= rdata.start;
          ptr     <= CW'(rd_idx) + CW'(1);
        end else if (last_fwd) begin
          status_r <= STAT_NOFIT;
        end
      end
      ST_SHDN: begin
        rd_idx <= ptr[IW-1:0];
        if (issue_fwd) begin
          ptr <= ptr + CW'(1);
        end
      end
      ST_FSCAN: begin
        rd_idx <= ptr[IW-1:0];
        if (issue_fwd) begin
          ptr <= ptr + CW'(1);
        end
        if (dv) begin
          if (below) begin
            prev_start <= rdata.start;
            prev_len   <= rdata.len;
            prev_valid <= 1'b1;
            if (last_fwd) begin
              pos <= cnt;
            end
          end else begin
            pos       <= CW'(rd_idx);
            cur_start <= rdata.start;
            cur_len   <= rdata.len;
            cur_valid <= 1'b1;
          end
        end
      end
      ST_FDECIDE: begin
        // first half of a two-sided merge; MERGE adds the right neighbor
        acc <= grow_left;
        ptr <= cnt;
        if (!left_hit && !right_hit && full) begin
          status_r <= STAT_FULL;
        end
      end
      ST_MERGE: begin
        ptr <= pos + CW'(1);
      end
      ST_SHUP: begin
        if (ptr > pos) begin
          rd_idx <= IW'(ptr - CW'(1));
          ptr    <= ptr - CW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_status <= status_r;
          out_start  <= start_r;
          out_count  <= COUNT_W'(cnt);
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {1'b0, out_count, out_start, out_status};

  // ------------------------------------------------------------- config port
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_blocks <= HEAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_HEAP_BLOCKS)) begin
      heap_blocks <= pwdata[LEN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEAP_BLOCKS) ? {{(32-LEN_W){1'b0}}, heap_blocks} : '0;

endmodule

// File: design/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
